[src/cfhp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package cfhp_pkg;

   localparam int HEADER_BYTES = 16;
   localparam int COUNT_BITS   = 24;
   localparam int MAGIC_END    = 4;
   localparam int VERSION_END  = 6;
   localparam int TYPE_END     = 8;
   localparam int REQUEST_END  = 12;
   localparam int LEN_BITS     = 32;
   localparam int SUM_BITS     = LEN_BITS + 1;
   localparam int TYPE_CODES   = 16;
   localparam int TYPE_SEL_BITS = $clog2(TYPE_CODES);

   localparam logic [COUNT_BITS-1:0] COUNT_MAX   = '1;
   localparam logic [31:0]           FRAME_MAGIC = 32'h5353_4350;

   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 24;

   localparam int RSP_DEPTH      = 4;
   localparam int RSP_PTR_BITS   = $clog2(RSP_DEPTH);
   localparam int RSP_COUNT_BITS = RSP_PTR_BITS + 1;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_EXPECTED_VERSION = 2'd0,
      CSR_MAX_PAYLOAD      = 2'd1,
      CSR_KNOWN_TYPE_MASK  = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_TRUNCATED = 3'd1,
      ST_MAGIC     = 3'd2,
      ST_VERSION   = 3'd3,
      ST_TYPE      = 3'd4,
      ST_TOO_LARGE = 3'd5,
      ST_MISMATCH  = 3'd6
   } status_type;

   typedef struct packed {
      logic [15:0] expected_version;
      logic [23:0] max_payload;
      logic [15:0] known_type_mask;
   } cfg_type;

   typedef struct packed {
      logic        is_verdict;
      logic [7:0]  payload_byte;
      status_type  status;
      logic [15:0] msg_type;
      logic [31:0] msg_id;
      logic [31:0] payload_length;
   } rsp_type;

   typedef struct packed {
      logic    push0;
      logic    push1;
      rsp_type data0;
      rsp_type data1;
   } push_type;

endpackage
`default_nettype wire

[src/cfhp_if.sv]
`timescale 1ns / 1ps
`default_nettype none
interface cfhp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] frame_byte;
   logic       frame_end;

   modport source (output valid, output frame_byte, output frame_end, input ready);
   modport sink (input valid, input frame_byte, input frame_end, output ready);
endinterface

interface cfhp_rsp_if;
   logic        valid;
   logic        ready;
   logic        is_verdict;
   logic [7:0]  payload_byte;
   logic [2:0]  status;
   logic [15:0] msg_type;
   logic [31:0] msg_id;
   logic [31:0] payload_length;

   modport source (output valid, output is_verdict, output payload_byte, output status,
                   output msg_type, output msg_id, output payload_length, input ready);
   modport sink (input valid, input is_verdict, input payload_byte, input status,
                 input msg_type, input msg_id, input payload_length, output ready);
endinterface
`default_nettype wire

[src/cfhp_regs.sv]
`timescale 1ns / 1ps
`default_nettype none
module cfhp_regs (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_wr_en,
   input  wire logic [cfhp_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [cfhp_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   output cfhp_pkg::cfg_type                        cfg
);
   import cfhp_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_EXPECTED_VERSION: cfg_in.expected_version = csr_wdata[15:0];
            CSR_MAX_PAYLOAD:      cfg_in.max_payload      = csr_wdata[23:0];
            CSR_KNOWN_TYPE_MASK:  cfg_in.known_type_mask  = csr_wdata[15:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.expected_version <= 16'd1;
         cfg_ff.max_payload      <= 24'd65536;
         cfg_ff.known_type_mask  <= 16'd16383;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;
endmodule
`default_nettype wire

[src/cfhp_parser.sv]
`timescale 1ns / 1ps
`default_nettype none
module cfhp_parser (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire cfhp_pkg::cfg_type cfg,
   cfhp_req_if.sink          req_if,
   input  wire logic         room,
   output cfhp_pkg::push_type push
);
   import cfhp_pkg::*;

   logic                  in_valid_ff, in_valid_in;
   logic [7:0]            byte_ff, byte_in;
   logic                  end_ff, end_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [31:0]           magic_ff, magic_in;
   logic [15:0]           version_ff, version_in;
   logic [15:0]           type_ff, type_in;
   logic [31:0]           request_ff, request_in;
   logic [31:0]           length_ff, length_in;

   logic                  consume;
   logic                  is_header;
   logic [COUNT_BITS-1:0] count_sat;
   logic [15:0]           type_nx;
   logic [31:0]           magic_nx, request_nx, length_nx;
   logic [15:0]           version_nx;
   status_type            status;
   rsp_type               payload_rsp, verdict_rsp;

   assign consume       = in_valid_ff && room;
   assign req_if.ready  = !in_valid_ff || consume;

   always_comb begin
      in_valid_in = in_valid_ff;
      byte_in     = byte_ff;
      end_in      = end_ff;
      if (req_if.ready) begin
         in_valid_in = req_if.valid;
         byte_in     = req_if.frame_byte;
         end_in      = req_if.frame_end;
      end
   end

   assign is_header = count_ff < COUNT_BITS'(HEADER_BYTES);
   assign count_sat = (count_ff == COUNT_MAX) ? count_ff : count_ff + COUNT_BITS'(1);

   always_comb begin
      magic_nx   = magic_ff;
      version_nx = version_ff;
      type_nx    = type_ff;
      request_nx = request_ff;
      length_nx  = length_ff;
      if (is_header) begin
         if (count_ff < COUNT_BITS'(MAGIC_END)) begin
            magic_nx = {magic_ff[23:0], byte_ff};
         end else if (count_ff < COUNT_BITS'(VERSION_END)) begin
            version_nx = {version_ff[7:0], byte_ff};
         end else if (count_ff < COUNT_BITS'(TYPE_END)) begin
            type_nx = {type_ff[7:0], byte_ff};
         end else if (count_ff < COUNT_BITS'(REQUEST_END)) begin
            request_nx = {request_ff[23:0], byte_ff};
         end else begin
            length_nx = {length_ff[23:0], byte_ff};
         end
      end
   end

   always_comb begin
      if (count_sat < COUNT_BITS'(HEADER_BYTES)) begin
         status = ST_TRUNCATED;
      end else if (magic_nx != FRAME_MAGIC) begin
         status = ST_MAGIC;
      end else if (version_nx != cfg.expected_version) begin
         status = ST_VERSION;
      end else if ((type_nx[15:TYPE_SEL_BITS] != '0)
                   || !cfg.known_type_mask[type_nx[TYPE_SEL_BITS-1:0]]) begin
         status = ST_TYPE;
      end else if (length_nx > LEN_BITS'(cfg.max_payload)) begin
         status = ST_TOO_LARGE;
      end else if ((count_sat == COUNT_MAX)
                   || (SUM_BITS'(count_sat)
                       != SUM_BITS'(length_nx) + SUM_BITS'(HEADER_BYTES))) begin
         status = ST_MISMATCH;
      end else begin
         status = ST_OK;
      end
   end

   always_comb begin
      payload_rsp              = '0;
      payload_rsp.is_verdict   = 1'b0;
      payload_rsp.payload_byte = byte_ff;
      payload_rsp.status       = ST_OK;

      verdict_rsp                = '0;
      verdict_rsp.is_verdict     = 1'b1;
      verdict_rsp.status         = status;
      verdict_rsp.msg_type       = type_nx;
      verdict_rsp.msg_id         = request_nx;
      verdict_rsp.payload_length = length_nx;

      push       = '0;
      push.data0 = verdict_rsp;
      push.data1 = verdict_rsp;
      if (consume) begin
         if (!is_header) begin
            push.push0 = 1'b1;
            push.data0 = payload_rsp;
            push.push1 = end_ff;
         end else begin
            push.push0 = end_ff;
         end
      end
   end

   always_comb begin
      count_in   = count_ff;
      magic_in   = magic_ff;
      version_in = version_ff;
      type_in    = type_ff;
      request_in = request_ff;
      length_in  = length_ff;
      if (consume) begin
         if (end_ff) begin
            count_in   = '0;
            magic_in   = '0;
            version_in = '0;
            type_in    = '0;
            request_in = '0;
            length_in  = '0;
         end else begin
            count_in   = count_sat;
            magic_in   = magic_nx;
            version_in = version_nx;
            type_in    = type_nx;
            request_in = request_nx;
            length_in  = length_nx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         count_ff    <= '0;
         magic_ff    <= '0;
         version_ff  <= '0;
         type_ff     <= '0;
         request_ff  <= '0;
         length_ff   <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         count_ff    <= count_in;
         magic_ff    <= magic_in;
         version_ff  <= version_in;
         type_ff     <= type_in;
         request_ff  <= request_in;
         length_ff   <= length_in;
      end
      byte_ff <= byte_in;
      end_ff  <= end_in;
   end
endmodule
`default_nettype wire

[src/cfhp_out_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none
module cfhp_out_fifo (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire cfhp_pkg::push_type push,
   output logic               room,
   cfhp_rsp_if.source         rsp_if
);
   import cfhp_pkg::*;

   rsp_type                   mem_ff [RSP_DEPTH];
   logic [RSP_PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [RSP_COUNT_BITS-1:0] count_ff, count_in;
   logic [RSP_PTR_BITS-1:0]   wr_next;
   logic [RSP_COUNT_BITS-1:0] n_push;
   logic                      pop;
   rsp_type                   head;

   assign room    = count_ff <= RSP_COUNT_BITS'(RSP_DEPTH - 2);
   assign pop     = rsp_if.valid && rsp_if.ready;
   assign wr_next = wr_ptr_ff + RSP_PTR_BITS'(1);
   assign n_push  = RSP_COUNT_BITS'(push.push0) + RSP_COUNT_BITS'(push.push1);

   assign wr_ptr_in = wr_ptr_ff + n_push[RSP_PTR_BITS-1:0];
   assign rd_ptr_in = rd_ptr_ff + RSP_PTR_BITS'(pop);
   assign count_in  = count_ff + n_push - RSP_COUNT_BITS'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.push0) begin
         mem_ff[wr_ptr_ff] <= push.data0;
      end
      if (push.push1) begin
         mem_ff[wr_next] <= push.data1;
      end
   end

   assign head                  = mem_ff[rd_ptr_ff];
   assign rsp_if.valid          = count_ff != '0;
   assign rsp_if.is_verdict     = head.is_verdict;
   assign rsp_if.payload_byte   = head.payload_byte;
   assign rsp_if.status         = head.status;
   assign rsp_if.msg_type       = head.msg_type;
   assign rsp_if.msg_id         = head.msg_id;
   assign rsp_if.payload_length = head.payload_length;
endmodule
`default_nettype wire

[src/control_frame_header_parser.sv]
`timescale 1ns / 1ps
`default_nettype none
// Parses a control frame fed one byte per transfer, final byte flagged. The first
// sixteen bytes form a big-endian header (magic, version, type, request id, length);
// each later byte leaves at once as a payload result, and the final byte adds a
// verdict carrying the status and header fields. A byte is taken every cycle while
// the result queue has room; a byte passes the input register and the parse logic
// into a four-entry result queue before its results leave. A final payload byte
// yields two results while the result port drains at most one per cycle, so the
// queue gains an entry; a second such byte arriving before a cycle without a result
// has let the queue catch up holds off the input until an entry drains.
module control_frame_header_parser (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_wr_en,
   input  wire logic [cfhp_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [cfhp_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   cfhp_req_if.sink                                req_if,
   cfhp_rsp_if.source                              rsp_if
);
   import cfhp_pkg::*;

   cfg_type  cfg;
   push_type push;
   logic     room;

   cfhp_regs u_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   cfhp_parser u_parser (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .req_if (req_if),
      .room   (room),
      .push   (push)
   );

   cfhp_out_fifo u_out_fifo (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .room   (room),
      .rsp_if (rsp_if)
   );
endmodule
`default_nettype wire
